/* rtl/core/gbf_pkg.sv */
// shared types and constants of the gliding biquad filter
`default_nettype none

package gbf_pkg;

   // coefficient format, Q4.28 signed
   localparam int COEF_W = 32;
   localparam int NCOEF = 5;
   localparam int CSR_IDX_W = 3;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic [CSR_IDX_W-1:0] coef_idx_type;

   // coefficient indexes, also the csr register indexes
   localparam coef_idx_type IDX_B0 = 3'd0;
   localparam coef_idx_type IDX_B1 = 3'd1;
   localparam coef_idx_type IDX_B2 = 3'd2;
   localparam coef_idx_type IDX_A1 = 3'd3;
   localparam coef_idx_type IDX_A2 = 3'd4;

   localparam coef_type COEF_ONE = 32'sd268435456;
   localparam logic signed [COEF_W:0] DIFF_LIMIT = 33'sd4194304;

   // datapath formats
   localparam int PROD_SHIFT = 16;
   localparam int OUT_SHIFT = 12;
   localparam int DELAY_W = 48;
   localparam int ACC_W = DELAY_W + 2;

   // glide step counter
   localparam int STEP_W = 4;

   // lerp divider: magnitude of a coefficient difference over steps left plus one
   // a difference of two full-range coefficients needs one bit more than a coefficient
   localparam int DIV_W = COEF_W + 1;
   localparam int DIVISOR_W = STEP_W + 1;

endpackage

`default_nettype wire

/* rtl/core/gbf_divider.sv */
// iterative unsigned restoring divider, one quotient bit per cycle
`default_nettype none

module gbf_divider (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   input  wire [gbf_pkg::DIV_W-1:0]       dividend,
   input  wire [gbf_pkg::DIVISOR_W-1:0]   divisor,
   output logic                           done,
   output logic [gbf_pkg::DIV_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(gbf_pkg::DIV_W + 1);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [gbf_pkg::DIV_W-1:0]       quo_ff, quo_in;
   logic [gbf_pkg::DIVISOR_W-1:0]   rem_ff, rem_in;
   logic [gbf_pkg::DIVISOR_W-1:0]   dsr_ff, dsr_in;
   logic [gbf_pkg::DIVISOR_W:0]     shifted;
   logic [gbf_pkg::DIVISOR_W:0]     trial;
   logic                            fits;

   // trial subtract of the divisor from the shifted partial remainder
   always_comb begin
      shifted = {rem_ff, quo_ff[gbf_pkg::DIV_W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      fits    = shifted >= {1'b0, dsr_ff};
   end

   // iteration control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(gbf_pkg::DIV_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[gbf_pkg::DIV_W-2:0], fits};
         rem_in = fits ? trial[gbf_pkg::DIVISOR_W-1:0] : shifted[gbf_pkg::DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* rtl/core/gliding_biquad_filter_core.sv */
// gliding biquad filter top level: sequencer, shared multiplier and coefficient glide
`default_nettype none

// Transposed direct form II biquad on signed samples with Q4.28 coefficients
// written through the csr port (0 b0, 1 b1, 2 b2, 3 a1, 4 a2). A sample is
// accepted, takes its five products through the single shared multiplier and
// its accumulator, then loads the output register. A sample that closes a
// glide step other than the last adds the lerp of all five coefficients
// through the bit-serial divider, once every SAMPLES_PER_STEP samples while
// a glide runs; the last step copies the latched targets. A change of any
// target by more than 1/64 restarts an 8-step glide; rsp_gliding reports
// whether the coefficients are still moving. A finished result waits in the
// output register while the next sample is accepted.

module gliding_biquad_filter_core #(
   parameter int GLIDE_STEPS      = 8,
   parameter int SAMPLES_PER_STEP = 32,
   parameter int SAMPLE_BITS      = 24
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire signed [SAMPLE_BITS-1:0]         req_sample_in,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]        rsp_sample_out,
   output logic                                 rsp_gliding,
   input  wire                                  csr_write_enable,
   input  wire [gbf_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire [gbf_pkg::COEF_W-1:0]            csr_write_data
);

   localparam int PROD_W  = SAMPLE_BITS + gbf_pkg::COEF_W;
   localparam int PHASE_W = (SAMPLES_PER_STEP > 1) ? $clog2(SAMPLES_PER_STEP) : 1;
   localparam int YSUM_W  = gbf_pkg::DELAY_W + 1;
   localparam int YSH_W   = YSUM_W - gbf_pkg::OUT_SHIFT;
   localparam int DIFF_W  = gbf_pkg::COEF_W + 1;
   localparam int LSUM_W  = gbf_pkg::COEF_W + 2;

   // sequencer states
   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_FILT       = 3'd1;
   localparam logic [2:0] ST_LERP_START = 3'd2;
   localparam logic [2:0] ST_LERP_WAIT  = 3'd3;
   localparam logic [2:0] ST_OUT        = 3'd4;

   // filter schedule slots
   localparam logic [2:0] FC_MUL_B0 = 3'd0;
   localparam logic [2:0] FC_MUL_B1 = 3'd1;
   localparam logic [2:0] FC_ROUND  = 3'd2;
   localparam logic [2:0] FC_MUL_A1 = 3'd3;
   localparam logic [2:0] FC_MUL_B2 = 3'd4;
   localparam logic [2:0] FC_MUL_A2 = 3'd5;
   localparam logic [2:0] FC_SUB_A2 = 3'd6;
   localparam logic [2:0] FC_LAST   = 3'd7;

   localparam logic signed [YSUM_W-1:0] ROUND_HALF =
      YSUM_W'(1) <<< (gbf_pkg::OUT_SHIFT - 1);

   // saturate the accumulator to the delay-term range
   function automatic logic signed [gbf_pkg::DELAY_W-1:0] sat_delay(
      input logic signed [gbf_pkg::ACC_W-1:0] v
   );
      logic [gbf_pkg::ACC_W-gbf_pkg::DELAY_W:0] top;
      top = v[gbf_pkg::ACC_W-1:gbf_pkg::DELAY_W-1];
      if ((&top) || !(|top)) begin
         return v[gbf_pkg::DELAY_W-1:0];
      end
      return v[gbf_pkg::ACC_W-1] ? {1'b1, {(gbf_pkg::DELAY_W-1){1'b0}}}
                                 : {1'b0, {(gbf_pkg::DELAY_W-1){1'b1}}};
   endfunction

   // state
   logic [2:0]                         state_ff, state_in;
   logic [2:0]                         fc_ff, fc_in;
   logic [gbf_pkg::CSR_IDX_W-1:0]      li_ff, li_in;
   gbf_pkg::coef_type                  target_ff [gbf_pkg::NCOEF];
   gbf_pkg::coef_type                  latched_ff [gbf_pkg::NCOEF];
   gbf_pkg::coef_type                  latched_in [gbf_pkg::NCOEF];
   gbf_pkg::coef_type                  active_ff [gbf_pkg::NCOEF];
   gbf_pkg::coef_type                  active_in [gbf_pkg::NCOEF];
   logic signed [gbf_pkg::DELAY_W-1:0] d1_ff, d1_in;
   logic signed [gbf_pkg::DELAY_W-1:0] d2_ff, d2_in;
   logic [gbf_pkg::STEP_W-1:0]         steps_ff, steps_in;
   logic [PHASE_W-1:0]                 phase_ff, phase_in;
   logic                               never_set_ff, never_set_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // datapath payload
   logic signed [SAMPLE_BITS-1:0]      x_ff, x_in;
   logic signed [SAMPLE_BITS-1:0]      y_ff, y_in;
   logic signed [PROD_W-1:0]           prod_ff, prod_in;
   logic signed [gbf_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic                               div_neg_ff, div_neg_in;
   logic signed [SAMPLE_BITS-1:0]      out_sample_ff, out_sample_in;
   logic                               out_gliding_ff, out_gliding_in;

   // combinational helpers
   logic                               big_change;
   logic signed [DIFF_W-1:0]           tdiff [gbf_pkg::NCOEF];
   logic [gbf_pkg::CSR_IDX_W-1:0]      coef_idx;
   logic                               mul_use_y;
   logic                               prod_load;
   gbf_pkg::coef_type                  coef_rd;
   logic signed [SAMPLE_BITS-1:0]      mul_a;
   logic signed [PROD_W-1:0]           prod_full;
   logic signed [gbf_pkg::ACC_W-1:0]   p_ext;
   logic signed [gbf_pkg::DELAY_W-1:0] acc_sat;
   logic signed [YSUM_W-1:0]           ysum;
   logic signed [YSH_W-1:0]            yshift;
   logic signed [SAMPLE_BITS-1:0]      y_sat;
   logic [PHASE_W:0]                   phase_next;
   logic signed [DIFF_W-1:0]           lerp_diff;
   logic [DIFF_W-1:0]                  lerp_mag;
   logic signed [LSUM_W-1:0]           lerp_q;
   logic signed [LSUM_W-1:0]           lerp_sum;
   logic                               div_start;
   logic                               div_done;
   logic [gbf_pkg::DIV_W-1:0]          div_quotient;
   logic [gbf_pkg::DIVISOR_W-1:0]      div_divisor;

   // target change detection against the latched targets
   always_comb begin
      big_change = 1'b0;
      for (int i = 0; i < gbf_pkg::NCOEF; i++) begin
         tdiff[i] = DIFF_W'(target_ff[i]) - DIFF_W'(latched_ff[i]);
         if (tdiff[i] > gbf_pkg::DIFF_LIMIT || tdiff[i] < -gbf_pkg::DIFF_LIMIT) begin
            big_change = 1'b1;
         end
      end
   end

   // shared multiplier with registered product
   assign coef_rd   = active_ff[coef_idx];
   assign mul_a     = mul_use_y ? y_ff : x_ff;
   assign prod_full = PROD_W'(mul_a) * PROD_W'(coef_rd);
   assign p_ext     = gbf_pkg::ACC_W'($signed(prod_ff[PROD_W-1:gbf_pkg::PROD_SHIFT]));

   // output rounding and saturation
   always_comb begin
      acc_sat = sat_delay(acc_ff);
      ysum    = YSUM_W'(acc_sat) + ROUND_HALF;
      yshift  = ysum[YSUM_W-1:gbf_pkg::OUT_SHIFT];
      if ((&yshift[YSH_W-1:SAMPLE_BITS-1]) || !(|yshift[YSH_W-1:SAMPLE_BITS-1])) begin
         y_sat = yshift[SAMPLE_BITS-1:0];
      end else begin
         y_sat = yshift[YSH_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                 : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   // lerp operands for the selected coefficient
   always_comb begin
      lerp_diff   = DIFF_W'(latched_ff[li_ff]) - DIFF_W'(active_ff[li_ff]);
      lerp_mag    = lerp_diff[DIFF_W-1] ? DIFF_W'(-lerp_diff) : DIFF_W'(lerp_diff);
      lerp_q      = div_neg_ff ? -LSUM_W'($signed({1'b0, div_quotient}))
                               : LSUM_W'($signed({1'b0, div_quotient}));
      lerp_sum    = LSUM_W'(active_ff[li_ff]) + lerp_q;
      div_divisor = {1'b0, steps_ff} + 1'b1;
   end

   assign phase_next = {1'b0, phase_ff} + 1'b1;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      fc_in          = fc_ff;
      li_in          = li_ff;
      latched_in     = latched_ff;
      active_in      = active_ff;
      d1_in          = d1_ff;
      d2_in          = d2_ff;
      steps_in       = steps_ff;
      phase_in       = phase_ff;
      never_set_in   = never_set_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      acc_in         = acc_ff;
      div_neg_in     = div_neg_ff;
      out_sample_in  = out_sample_ff;
      out_gliding_in = out_gliding_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      coef_idx       = gbf_pkg::IDX_B0;
      mul_use_y      = 1'b0;
      prod_load      = 1'b0;
      div_start      = 1'b0;
      req_ready      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // latch targets and decide between copy, glide or keep
               x_in       = req_sample_in;
               latched_in = target_ff;
               if (never_set_ff) begin
                  never_set_in = 1'b0;
                  steps_in     = '0;
                  phase_in     = '0;
                  active_in    = target_ff;
               end else if (big_change) begin
                  steps_in = gbf_pkg::STEP_W'(GLIDE_STEPS);
                  phase_in = '0;
               end else if (steps_ff == '0) begin
                  active_in = target_ff;
               end
               fc_in    = FC_MUL_B0;
               state_in = ST_FILT;
            end
         end
         ST_FILT: begin
            fc_in = fc_ff + 1'b1;
            case (fc_ff)
               FC_MUL_B0: begin
                  coef_idx  = gbf_pkg::IDX_B0;
                  prod_load = 1'b1;
                  acc_in    = gbf_pkg::ACC_W'(d1_ff);
               end
               FC_MUL_B1: begin
                  coef_idx  = gbf_pkg::IDX_B1;
                  prod_load = 1'b1;
                  acc_in    = acc_ff + p_ext;
               end
               FC_ROUND: begin
                  y_in   = y_sat;
                  acc_in = gbf_pkg::ACC_W'(d2_ff);
               end
               FC_MUL_A1: begin
                  coef_idx  = gbf_pkg::IDX_A1;
                  mul_use_y = 1'b1;
                  prod_load = 1'b1;
                  acc_in    = acc_ff + p_ext;
               end
               FC_MUL_B2: begin
                  coef_idx  = gbf_pkg::IDX_B2;
                  prod_load = 1'b1;
                  acc_in    = acc_ff - p_ext;
               end
               FC_MUL_A2: begin
                  d1_in     = acc_sat;
                  coef_idx  = gbf_pkg::IDX_A2;
                  mul_use_y = 1'b1;
                  prod_load = 1'b1;
                  acc_in    = p_ext;
               end
               FC_SUB_A2: begin
                  acc_in = acc_ff - p_ext;
               end
               FC_LAST: begin
                  d2_in    = acc_sat;
                  state_in = ST_OUT;
                  // glide step timing
                  if (steps_ff != '0) begin
                     if (phase_next >= (PHASE_W + 1)'(SAMPLES_PER_STEP)) begin
                        phase_in = '0;
                        steps_in = steps_ff - 1'b1;
                        if (steps_ff == gbf_pkg::STEP_W'(1)) begin
                           active_in = latched_ff;
                        end else begin
                           li_in    = gbf_pkg::IDX_B0;
                           state_in = ST_LERP_START;
                        end
                     end else begin
                        phase_in = phase_next[PHASE_W-1:0];
                     end
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_LERP_START: begin
            coef_idx   = li_ff;
            div_start  = 1'b1;
            div_neg_in = lerp_diff[DIFF_W-1];
            state_in   = ST_LERP_WAIT;
         end
         ST_LERP_WAIT: begin
            coef_idx = li_ff;
            if (div_done) begin
               active_in[li_ff] = lerp_sum[gbf_pkg::COEF_W-1:0];
               if (li_ff == gbf_pkg::IDX_A2) begin
                  state_in = ST_OUT;
               end else begin
                  li_in    = li_ff + 1'b1;
                  state_in = ST_LERP_START;
               end
            end
         end
         ST_OUT: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               out_sample_in  = y_ff;
               out_gliding_in = steps_ff != '0;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign prod_in = prod_load ? prod_full : prod_ff;

   // lerp divider
   gbf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (lerp_mag[gbf_pkg::DIV_W-1:0]),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fc_ff        <= FC_MUL_B0;
         li_ff        <= gbf_pkg::IDX_B0;
         d1_ff        <= '0;
         d2_ff        <= '0;
         steps_ff     <= '0;
         phase_ff     <= '0;
         never_set_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < gbf_pkg::NCOEF; i++) begin
            latched_ff[i] <= (i == 0) ? gbf_pkg::COEF_ONE : '0;
            active_ff[i]  <= (i == 0) ? gbf_pkg::COEF_ONE : '0;
         end
      end else begin
         state_ff     <= state_in;
         fc_ff        <= fc_in;
         li_ff        <= li_in;
         d1_ff        <= d1_in;
         d2_ff        <= d2_in;
         steps_ff     <= steps_in;
         phase_ff     <= phase_in;
         never_set_ff <= never_set_in;
         rsp_valid_ff <= rsp_valid_in;
         latched_ff   <= latched_in;
         active_ff    <= active_in;
      end
   end

   // target coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gbf_pkg::NCOEF; i++) begin
            target_ff[i] <= (i == 0) ? gbf_pkg::COEF_ONE : '0;
         end
      end else if (csr_write_enable && csr_index < gbf_pkg::CSR_IDX_W'(gbf_pkg::NCOEF)) begin
         target_ff[csr_index] <= csr_write_data;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      x_ff           <= x_in;
      y_ff           <= y_in;
      prod_ff        <= prod_in;
      acc_ff         <= acc_in;
      div_neg_ff     <= div_neg_in;
      out_sample_ff  <= out_sample_in;
      out_gliding_ff <= out_gliding_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = out_sample_ff;
   assign rsp_gliding    = out_gliding_ff;

endmodule

`default_nettype wire
